// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define PFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define PFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pfb_pkg.sv =====
// Package: constants, request codes, state type and helpers of the page framebuffer.
package pfb_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_NEXT  = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PIX_WR,
        S_CLR,
        S_MRD,
        S_MCHK,
        S_FRD,
        S_RESP
    } t_state;

    // Index of the lowest set bit of a mark word.
    function automatic logic [2:0] first_set(input logic [7:0] word);
        logic [2:0] idx;
        idx = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (word[b]) begin
                idx = 3'(b);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/pfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/page_framebuffer_dirty_flush.sv =====
// Top level: monochrome page framebuffer with per-byte dirty marks and change scan.
//
//  channel  direction  handshake                  payload
//  request  in         i_in_valid / o_in_stall    i_req_type i_pixel_x i_pixel_y i_pixel_on
//  result   out        o_out_valid / i_out_stall  o_found o_page o_column o_data
//
// Steps per request: a pixel write reads its frame byte and mark word, then writes
// both back; request code 3 and off-screen writes go straight to the result; clear
// screen sweeps PAGES * 2**clog2(COLUMNS) frame bytes, one per cycle; next change
// reads mark words one at a time (eight marks per word, one read port), then the byte on a hit.
// Reset: synchronous; a clearing pass over all PAGES * 2**clog2(COLUMNS) frame bytes then
// zeroes the frame and mark memories, with o_in_stall high throughout.
// A stalled result holds in the output register; one more request may be taken
// meanwhile and finishes once the output register frees up.
module page_framebuffer_dirty_flush #(
    parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfb_pkg::PAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [6:0] i_pixel_x,
    input  logic [5:0] i_pixel_y,
    input  logic       i_pixel_on,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_found,
    output logic [2:0] o_page,
    output logic [6:0] o_column,
    output logic [7:0] o_data
);

    import pfb_pkg::*;

    // Frame bytes live at {page, column}; columns pad up to a power of two.
    localparam int CW  = $clog2(COLUMNS);
    localparam int PW  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int FD  = PAGES * (1 << CW);
    localparam int FAW = $clog2(FD);
    // Dirty marks are packed eight columns to a word.
    localparam int MD  = FD / 8;
    localparam int MAW = (MD > 1) ? $clog2(MD) : 1;

    t_state r_state, n_state;

    logic [FAW-1:0] r_cnt, n_cnt;        // sweep pointer over frame bytes
    logic [MAW-1:0] r_widx, n_widx;      // scan pointer over mark words
    logic [FAW-1:0] r_faddr, n_faddr;    // pixel write target byte
    logic [MAW-1:0] r_maddr, n_maddr;    // pixel write target mark word
    logic [2:0]     r_mbit, n_mbit;
    logic [2:0]     r_ybit, n_ybit;
    logic           r_on, n_on;
    logic           r_clr_mark, n_clr_mark;

    logic           r_res_found, n_res_found;
    logic [PW-1:0]  r_res_page, n_res_page;
    logic [CW-1:0]  r_res_col, n_res_col;
    logic [7:0]     r_res_data, n_res_data;

    logic           r_out_valid, n_out_valid;
    logic           r_found, n_found;
    logic [2:0]     r_page, n_page;
    logic [6:0]     r_column, n_column;
    logic [7:0]     r_data, n_data;

    // Memory ports
    logic           f_we, f_re;
    logic [FAW-1:0] f_waddr, f_raddr;
    logic [7:0]     f_wdata, f_rdata;
    logic           m_we, m_re;
    logic [MAW-1:0] m_waddr, m_raddr;
    logic [7:0]     m_wdata, m_rdata;

    // Decoded input pixel
    logic [2:0]      in_pg;
    logic [PW-1:0]   in_pgw;
    logic [CW-1:0]   in_col;
    logic            in_onscreen;
    logic [FAW-1:0]  in_faddr;
    logic [MAW-1:0]  in_maddr;

    // Scan hit
    logic [2:0]      hit_bit;
    logic [MAW+2:0]  hit_cell;

    // Sweep helpers
    logic [CW-1:0]   sw_col;
    logic [7:0]      sw_mask;

    logic            in_acc;

    assign in_pg       = i_pixel_y[5:3];
    assign in_pgw      = PW'(in_pg);
    assign in_col      = CW'(i_pixel_x);
    assign in_onscreen = (int'(i_pixel_x) < COLUMNS) && (int'(in_pg) < PAGES);
    assign in_faddr    = FAW'({in_pgw, in_col});
    assign in_maddr    = MAW'({in_pgw, in_col} >> 3);

    assign hit_bit  = first_set(m_rdata);
    assign hit_cell = {r_widx, hit_bit};

    assign sw_col = r_cnt[CW-1:0];
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            sw_mask[b] = r_clr_mark && ((int'(sw_col) + b) < COLUMNS);
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    pfb_ram #(
        .WIDTH (8),
        .DEPTH (FD)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_re    (f_re),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    pfb_ram #(
        .WIDTH (8),
        .DEPTH (MD)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_clr_mark  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_clr_mark  <= n_clr_mark;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx      <= n_widx;
        r_faddr     <= n_faddr;
        r_maddr     <= n_maddr;
        r_mbit      <= n_mbit;
        r_ybit      <= n_ybit;
        r_on        <= n_on;
        r_res_found <= n_res_found;
        r_res_page  <= n_res_page;
        r_res_col   <= n_res_col;
        r_res_data  <= n_res_data;
        r_found     <= n_found;
        r_page      <= n_page;
        r_column    <= n_column;
        r_data      <= n_data;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_widx      = r_widx;
        n_faddr     = r_faddr;
        n_maddr     = r_maddr;
        n_mbit      = r_mbit;
        n_ybit      = r_ybit;
        n_on        = r_on;
        n_clr_mark  = r_clr_mark;
        n_res_found = r_res_found;
        n_res_page  = r_res_page;
        n_res_col   = r_res_col;
        n_res_data  = r_res_data;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_page      = r_page;
        n_column    = r_column;
        n_data      = r_data;

        f_we    = 1'b0;
        f_waddr = r_cnt;
        f_wdata = 8'd0;
        f_re    = 1'b0;
        f_raddr = in_faddr;
        m_we    = 1'b0;
        m_waddr = MAW'(r_cnt >> 3);
        m_wdata = sw_mask;
        m_re    = 1'b0;
        m_raddr = in_maddr;

        // Drop the output beat once the sink takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT, S_CLR: begin
                // Sweep: zero each frame byte, rewrite each mark word on its first byte.
                f_we = 1'b1;
                m_we = (r_cnt[2:0] == 3'd0);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == FAW'(FD - 1)) begin
                    n_cnt = '0;
                    n_state = (r_state == S_INIT) ? S_IDLE : S_RESP;
                end
            end
            S_IDLE: begin
                n_res_found = 1'b0;
                n_res_page  = '0;
                n_res_col   = '0;
                n_res_data  = 8'd0;
                if (in_acc) begin
                    case (i_req_type)
                        REQ_PIXEL: begin
                            // Start the read half of the read-modify-write.
                            n_faddr = in_faddr;
                            n_maddr = in_maddr;
                            n_mbit  = i_pixel_x[2:0];
                            n_ybit  = i_pixel_y[2:0];
                            n_on    = i_pixel_on;
                            if (in_onscreen) begin
                                f_re    = 1'b1;
                                m_re    = 1'b1;
                                n_state = S_PIX_WR;
                            end else begin
                                n_state = S_RESP;
                            end
                        end
                        REQ_CLEAR: begin
                            n_cnt      = '0;
                            n_clr_mark = 1'b1;
                            n_state    = S_CLR;
                        end
                        REQ_NEXT: begin
                            n_widx  = '0;
                            n_state = S_MRD;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_PIX_WR: begin
                f_we    = 1'b1;
                f_waddr = r_faddr;
                f_wdata = r_on ? (f_rdata | (8'd1 << r_ybit))
                               : (f_rdata & ~(8'd1 << r_ybit));
                m_we    = 1'b1;
                m_waddr = r_maddr;
                m_wdata = m_rdata | (8'd1 << r_mbit);
                n_state = S_RESP;
            end
            S_MRD: begin
                m_re    = 1'b1;
                m_raddr = r_widx;
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (m_rdata != 8'd0) begin
                    // Hit: fetch the byte and retire its mark.
                    f_re        = 1'b1;
                    f_raddr     = FAW'(hit_cell);
                    m_we        = 1'b1;
                    m_waddr     = r_widx;
                    m_wdata     = m_rdata & ~(8'd1 << hit_bit);
                    n_res_found = 1'b1;
                    n_res_page  = PW'(hit_cell >> CW);
                    n_res_col   = CW'(hit_cell);
                    n_state     = S_FRD;
                end else if (r_widx == MAW'(MD - 1)) begin
                    n_state = S_RESP;
                end else begin
                    n_widx  = r_widx + 1'b1;
                    n_state = S_MRD;
                end
            end
            S_FRD: begin
                n_res_data = f_rdata;
                n_state    = S_RESP;
            end
            S_RESP: begin
                // Hold until the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_page      = 3'(r_res_page);
                    n_column    = 7'(r_res_col);
                    n_data      = r_res_data;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_page      = r_page;
    assign o_column    = r_column;
    assign o_data      = r_data;

endmodule

// ===== rtl/pfb_check.sv =====
// Port-level checker of the page framebuffer, bound to the top level.
`include "assert_macros.svh"

module pfb_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_req_type,
    input logic [6:0] i_pixel_x,
    input logic [5:0] i_pixel_y,
    input logic       i_pixel_on,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_found,
    input logic [2:0] o_page,
    input logic [6:0] o_column,
    input logic [7:0] o_data
);

    // Reset leaves no beat out and starts the clearing pass.
    `PFB_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid && o_in_stall, "reset did not clear output or start the clearing pass")

    // A stalled result beat holds.
    `PFB_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_found) && $stable(o_page) && $stable(o_column) && $stable(o_data)), "stalled result changed")

    // A miss or a write answer carries all-zero fields.
    `PFB_ASSERT(a_miss_zero, i_clk, i_rst_n, (o_out_valid && !o_found) |-> (o_page == 3'd0 && o_column == 7'd0 && o_data == 8'd0), "result without hit has nonzero fields")

    // One request at a time: busy right after a request beat.
    `PFB_ASSERT(a_busy_after, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "request taken while previous still in flight")

endmodule

bind page_framebuffer_dirty_flush pfb_check u_pfb_check (.*);

// ===== bench/tb_page_framebuffer_dirty_flush.sv =====
// Testbench for the page framebuffer with dirty-byte tracking and change scan.
`timescale 1ns / 1ps

module tb_page_framebuffer_dirty_flush;
    import pfb_pkg::*;

    // Geometry of the screen as instantiated: 128 columns by 8 pages of 8 rows.
    localparam int NUM_COLS   = COLUMNS_DEF;
    localparam int NUM_PAGES  = PAGES_DEF;
    localparam int NUM_BYTES  = NUM_COLS * NUM_PAGES;

    // The package names three request codes; the fourth must be ignored.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_BEATS   = 1000;
    // Window of random beats driven with no gaps and no output stalls.
    localparam int QUIET_FIRST    = 400;
    localparam int QUIET_LAST     = 550;
    // Long output hold-off, started once this many request beats have gone in.
    localparam int PRESSURE_AT    = 250;
    localparam int PRESSURE_LEN   = 600;
    // A change scan runs over all 128 mark words.
    localparam int DRAIN_CYCLES   = 400;
    // Slowest legal run: each beat may take a clear sweep, the longest gap and a
    // stall, over roughly 1025 beats, plus the clearing pass after reset.
    localparam int CYCLE_LIMIT    = 5_000_000;

    typedef struct packed {
        logic       found;
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] data;
    } t_frame_change;

    // Shadow copy of the frame and its dirty marks; predicts one result per
    // request beat and checks result beats against them in order.
    class dirty_flush_scoreboard;
        logic [7:0]    shadow_bytes [NUM_BYTES];
        bit            shadow_dirty [NUM_BYTES];
        t_frame_change pending_changes [$];
        int            mismatches;

        function new();
            foreach (shadow_bytes[i]) begin
                shadow_bytes[i] = 8'h00;
                shadow_dirty[i] = 1'b0;
            end
            mismatches = 0;
        endfunction

        function void note_request(logic [1:0] req, logic [6:0] x, logic [5:0] y,
                                   logic on);
            t_frame_change change;
            int            idx;
            change = '0;
            case (req)
                REQ_PIXEL: begin
                    // Page is y/8, bit is y%8; drop writes that miss the screen.
                    if (int'(x) < NUM_COLS && int'(y[5:3]) < NUM_PAGES) begin
                        idx = int'(y[5:3]) * NUM_COLS + int'(x);
                        shadow_bytes[idx][y[2:0]] = on;
                        shadow_dirty[idx] = 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    foreach (shadow_bytes[i]) begin
                        shadow_bytes[i] = 8'h00;
                        shadow_dirty[i] = 1'b1;
                    end
                end
                REQ_NEXT: begin
                    // Scan pages in order, columns within a page.
                    for (idx = 0; idx < NUM_BYTES; idx++) begin
                        if (shadow_dirty[idx]) begin
                            shadow_dirty[idx] = 1'b0;
                            change.found  = 1'b1;
                            change.page   = 3'(idx / NUM_COLS);
                            change.column = 7'(idx % NUM_COLS);
                            change.data   = shadow_bytes[idx];
                            break;
                        end
                    end
                end
                default: ;
            endcase
            pending_changes.push_back(change);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_frame_change got);
            t_frame_change want;
            if (pending_changes.size() == 0) begin
                $error("result beat with nothing outstanding: found %0d page %0d %s",
                       got.found, got.page,
                       $sformatf("column %0d data %0d", got.column, got.data));
                mismatches++;
                return;
            end
            want = pending_changes.pop_front();
            compare_field("found",  8'(want.found),  8'(got.found));
            compare_field("page",   8'(want.page),   8'(got.page));
            compare_field("column", 8'(want.column), 8'(got.column));
            compare_field("data",   want.data,       got.data);
        endfunction

        function int outstanding();
            return pending_changes.size();
        endfunction

        function bit all_clear();
            if (pending_changes.size() != 0) begin
                $error("%0d expected results never arrived", pending_changes.size());
                mismatches++;
            end
            return mismatches == 0;
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_req_type  = 2'd0;
    logic [6:0] i_pixel_x   = 7'd0;
    logic [5:0] i_pixel_y   = 6'd0;
    logic       i_pixel_on  = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_found;
    logic [2:0] o_page;
    logic [6:0] o_column;
    logic [7:0] o_data;

    dirty_flush_scoreboard sb;
    int  beats_sent  = 0;
    int  cycle_count = 0;
    bit  quiet       = 1'b0;

    page_framebuffer_dirty_flush u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_pixel_on  (i_pixel_on),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .o_page      (o_page),
        .o_column    (o_column),
        .o_data      (o_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    // Abort a hung run; the limit is several times the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offer one request beat and hold it until accepted. Entered and left at
    // a rising edge; valid stays high into the next beat when no gap is drawn,
    // so it is never dropped and raised in the same step.
    task automatic send_beat(logic [1:0] req, logic [6:0] x, logic [5:0] y, logic on);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        i_pixel_on <= on;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_request(req, x, y, on);
        beats_sent++;
    endtask

    // Random mix: pixel writes and change requests dominate, clears are rare
    // since each one sweeps the whole frame and dirties every byte.
    task automatic random_beat();
        int         r;
        logic [1:0] req;
        logic [6:0] x;
        logic [5:0] y;
        r = $urandom_range(0, 99);
        if (r < 48) begin
            req = REQ_PIXEL;
        end else if (r < 96) begin
            req = REQ_NEXT;
        end else if (r < 97) begin
            req = REQ_CLEAR;
        end else begin
            req = REQ_UNUSED;
        end
        // Crowd a quarter of the writes into a few bytes so read-modify-write
        // hits bytes that already hold lit pixels.
        if ($urandom_range(0, 3) == 0) begin
            x = 7'($urandom_range(0, 3));
            y = 6'($urandom_range(0, 15));
        end else begin
            x = 7'($urandom);
            y = 6'($urandom);
        end
        send_beat(req, x, y, 1'($urandom));
    endtask

    // Result side: check each accepted result beat, then pick the next stall
    // level. One long hold-off lets the block fill and push back on requests.
    initial begin : result_side
        int            hold_left;
        int            run_left;
        bit            pressure_done;
        logic          stall_level;
        t_frame_change got;
        hold_left     = 0;
        run_left      = 0;
        pressure_done = 1'b0;
        stall_level   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = {o_found, o_page, o_column, o_data};
                sb.check_result(got);
            end
            if (!pressure_done && beats_sent >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_level = 1'b1;
            end else if (quiet) begin
                stall_level = 1'b0;
                run_left    = 0;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                case ($urandom_range(0, 19))
                    0: begin
                        stall_level = 1'b1;
                        run_left    = $urandom_range(15, 60);
                    end
                    1, 2, 3, 4, 5: begin
                        stall_level = 1'b1;
                        run_left    = $urandom_range(0, 2);
                    end
                    default: begin
                        stall_level = 1'b0;
                        run_left    = $urandom_range(0, 7);
                    end
                endcase
            end
            i_out_stall <= stall_level;
        end
    end

    // Request side: reset, a directed opening, then the random body.
    initial begin : request_side
        int n;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Nothing dirty yet.
        send_beat(REQ_NEXT, 7'd0, 6'd0, 1'b0);
        // Opposite corners, then a second bit and a cleared bit in one byte.
        send_beat(REQ_PIXEL, 7'd0, 6'd0, 1'b1);
        send_beat(REQ_PIXEL, 7'd127, 6'd63, 1'b1);
        send_beat(REQ_PIXEL, 7'd0, 6'd7, 1'b1);
        send_beat(REQ_PIXEL, 7'd0, 6'd0, 1'b0);
        send_beat(REQ_NEXT, 7'd0, 6'd0, 1'b0);
        send_beat(REQ_NEXT, 7'd0, 6'd0, 1'b0);
        send_beat(REQ_NEXT, 7'd0, 6'd0, 1'b0);
        // Unused code with every payload bit set must change nothing.
        send_beat(REQ_UNUSED, 7'd127, 6'd63, 1'b1);
        send_beat(REQ_NEXT, 7'd0, 6'd0, 1'b0);
        // Alternating payload bits; a darkened pixel still dirties its byte.
        send_beat(REQ_PIXEL, 7'd85, 6'd42, 1'b1);
        send_beat(REQ_PIXEL, 7'd42, 6'd21, 1'b0);
        send_beat(REQ_NEXT, 7'd0, 6'd0, 1'b0);
        send_beat(REQ_NEXT, 7'd0, 6'd0, 1'b0);
        // Clear dirties every byte; a write lands on an already dirty mark.
        send_beat(REQ_CLEAR, 7'd0, 6'd0, 1'b0);
        send_beat(REQ_NEXT, 7'd0, 6'd0, 1'b0);
        send_beat(REQ_PIXEL, 7'd1, 6'd3, 1'b1);
        send_beat(REQ_NEXT, 7'd0, 6'd0, 1'b0);
        send_beat(REQ_CLEAR, 7'd127, 6'd63, 1'b1);
        send_beat(REQ_CLEAR, 7'd0, 6'd0, 1'b0);
        send_beat(REQ_NEXT, 7'd0, 6'd0, 1'b0);
        send_beat(REQ_UNUSED, 7'd0, 6'd0, 1'b0);

        for (n = 0; n < RANDOM_BEATS; n++) begin
            quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
            random_beat();
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        // Drain every expected result, then allow one full scan of quiet time
        // so a stray extra result still gets caught.
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.all_clear()) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
